>>> src/tcw_pkg.sv
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    // Work kinds sorted out by the front end
    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_NL,
        OP_VT,
        OP_FF,
        OP_CR
    } op_t;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Register indexes
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_COLUMNS = 3'd1;
    localparam logic [2:0] REG_ROWS    = 3'd2;
    localparam logic [2:0] REG_FORE    = 3'd3;
    localparam logic [2:0] REG_BACK    = 3'd4;

    // Queued work item
    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [10:0] idx;
    } item_t;

    // Settings handed from the register block to the back end
    typedef struct packed {
        logic [7:0] ecols;
        logic [7:0] attr;
        logic       fix;
    } geo_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

>>> src/text_console_writer_unit.sv
// Top level of the text console writer.
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: char_code, cell_index; tuser: command
// m_*       out  m_tvalid/m_tready   tdata: cell_entry, cursor_col, cursor_row
// APB       in   psel&penable&pwrite enable, columns, rows, fore/back colour
//
// After reset all MAX_CELLS cells of the store are swept to zero, with s_tready low.
// A read, a plain put or a tab spends most of its time in the back end in the serial
// divider that turns the linear cursor into column and row; newline and carriage
// return add one more divider pass. Form feed adds a pass over every screen cell,
// and each scroll a copy and a blanking pass through the single store write port.
// A two-beat queue takes input while the back end or a waiting result beat stalls.
`timescale 1ns / 1ps
module text_console_writer_unit #(
    parameter int MAX_CELLS = 2048,
    parameter int TAB_WIDTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] cell_entry, [22:16] cursor_col,
                                   // [28:23] cursor_row, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CELL_W = $clog2(MAX_CELLS + 1);

    logic                enable;
    tcw_pkg::geo_t       geo;
    logic [CELL_W-1:0]   cells;
    tcw_pkg::back_stat_t stat;
    logic                pop;
    logic                q_valid;
    tcw_pkg::item_t      q_item;

    assign pready = 1'b1;

    tcw_cfg #(.MAX_CELLS(MAX_CELLS), .CELL_W(CELL_W)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .enable  (enable),
        .geo     (geo),
        .cells   (cells)
    );

    // front: accept and classify
    tcw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .enable   (enable),
        .stat     (stat),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    // back: execute and report
    tcw_back #(.MAX_CELLS(MAX_CELLS), .TAB_WIDTH(TAB_WIDTH), .CELL_W(CELL_W)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .geo      (geo),
        .cells    (cells),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

>>> src/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/tcw_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tcw_div #(
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] dividend,
    input  logic [7:0]    divisor,
    output logic          busy,
    output logic          done,
    output logic [AW-1:0] quot,
    output logic [7:0]    rem
);
    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0] quo_reg;
    logic [7:0]    rem_reg;
    logic [7:0]    dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [8:0]    shifted;
    logic          take;

    assign shifted = {rem_reg, quo_reg[AW-1]};
    assign take    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg <= dividend;
                rem_reg <= '0;
                dvs_reg <= divisor;
                cnt_reg <= CW'(AW);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= take ? 8'(shifted - {1'b0, dvs_reg}) : shifted[7:0];
                quo_reg <= {quo_reg[AW-2:0], take};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = cnt_reg != '0;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule

>>> src/tcw_cfg.sv
// Register block and screen geometry.
`timescale 1ns / 1ps
module tcw_cfg #(
    parameter int MAX_CELLS = 2048,
    parameter int CELL_W    = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              enable,
    output tcw_pkg::geo_t     geo,
    output logic [CELL_W-1:0] cells
);
    localparam int COLS_LIM = (MAX_CELLS < 128) ? MAX_CELLS : 128;

    logic              enable_reg;
    logic [7:0]        columns_reg;
    logic [6:0]        rows_reg;
    logic [3:0]        fore_reg;
    logic [3:0]        back_reg;
    logic [7:0]        ecols_reg;
    logic [CELL_W-1:0] cells_reg;
    logic              geo_wr_reg;
    logic              fix_reg;
    logic              wr;
    logic [2:0]        idx;
    logic [7:0]        ecols;
    logic [6:0]        rows_c;
    logic [6:0]        lim;
    logic [6:0]        erows;
    logic [14:0]       prod;
    logic [6:0]        lim_tab [128];

    // Row limit per column count, worked out at elaboration
    for (genvar g = 0; g < 128; g++)
    begin : g_lim
        localparam int L  = MAX_CELLS / (g + 1);
        localparam int LC = (L > 64) ? 64 : L;
        assign lim_tab[g] = 7'(LC);
    end

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[4:2];

    always_comb
    begin
        if (columns_reg == 8'd0)
        begin
            ecols = 8'd1;
        end
        else if (columns_reg > 8'(COLS_LIM))
        begin
            ecols = 8'(COLS_LIM);
        end
        else
        begin
            ecols = columns_reg;
        end
        if (rows_reg == 7'd0)
        begin
            rows_c = 7'd1;
        end
        else if (rows_reg > 7'd64)
        begin
            rows_c = 7'd64;
        end
        else
        begin
            rows_c = rows_reg;
        end
        lim   = lim_tab[7'(ecols - 8'd1)];
        erows = (rows_c > lim) ? lim : rows_c;
        prod  = 15'(ecols) * 15'(erows);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            columns_reg <= 8'd80;
            rows_reg    <= 7'd25;
            fore_reg    <= 4'd15;
            back_reg    <= 4'd0;
            ecols_reg   <= 8'd80;
            cells_reg   <= CELL_W'(2000);
            geo_wr_reg  <= 1'b0;
            fix_reg     <= 1'b0;
        end
        else
        begin
            ecols_reg  <= ecols;
            cells_reg  <= CELL_W'(prod);
            geo_wr_reg <= 1'b0;
            fix_reg    <= geo_wr_reg;
            if (wr)
            begin
                case (idx)
                    tcw_pkg::REG_ENABLE:  enable_reg <= pwdata[0];
                    tcw_pkg::REG_COLUMNS:
                    begin
                        columns_reg <= pwdata[7:0];
                        geo_wr_reg  <= 1'b1;
                    end
                    tcw_pkg::REG_ROWS:
                    begin
                        rows_reg   <= pwdata[6:0];
                        geo_wr_reg <= 1'b1;
                    end
                    tcw_pkg::REG_FORE:    fore_reg <= pwdata[3:0];
                    tcw_pkg::REG_BACK:    back_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            tcw_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            tcw_pkg::REG_COLUMNS: prdata = {24'd0, columns_reg};
            tcw_pkg::REG_ROWS:    prdata = {25'd0, rows_reg};
            tcw_pkg::REG_FORE:    prdata = {28'd0, fore_reg};
            tcw_pkg::REG_BACK:    prdata = {28'd0, back_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign enable    = enable_reg;
    assign geo.ecols = ecols_reg;
    assign geo.attr  = {back_reg, fore_reg};
    assign geo.fix   = fix_reg;
    assign cells     = cells_reg;
endmodule

>>> src/tcw_front.sv
// Input acceptance, byte classification and a two-entry work queue.
`timescale 1ns / 1ps
module tcw_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  enable,
    input  tcw_pkg::back_stat_t   stat,
    input  logic                  pop,
    output logic                  q_valid,
    output tcw_pkg::item_t        q_item
);
    tcw_pkg::item_t slot_reg [2];
    logic           wp_reg;
    logic           rp_reg;
    logic [1:0]     cnt_reg;
    tcw_pkg::item_t cls;
    logic           push;
    logic [7:0]     ch;

    assign ch = s_tdata[7:0];

    always_comb
    begin
        cls.ch  = ch;
        cls.idx = s_tdata[18:8];
        if (s_tuser[0] == tcw_pkg::CMD_READ)
        begin
            cls.op = tcw_pkg::OP_READ;
        end
        else if (!enable)
        begin
            cls.op = tcw_pkg::OP_NOP;
        end
        else if (ch >= tcw_pkg::CH_SPACE && ch <= tcw_pkg::CH_TILDE)
        begin
            cls.op = tcw_pkg::OP_PRINT;
        end
        else
        begin
            case (ch)
                tcw_pkg::CH_BS:  cls.op = tcw_pkg::OP_BS;
                tcw_pkg::CH_TAB: cls.op = tcw_pkg::OP_TAB;
                tcw_pkg::CH_NL:  cls.op = tcw_pkg::OP_NL;
                tcw_pkg::CH_VT:  cls.op = tcw_pkg::OP_VT;
                tcw_pkg::CH_FF:  cls.op = tcw_pkg::OP_FF;
                tcw_pkg::CH_CR:  cls.op = tcw_pkg::OP_CR;
                default:         cls.op = tcw_pkg::OP_NOP;
            endcase
        end
    end

    assign s_tready = (cnt_reg != 2'd2) && !stat.clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end
endmodule

>>> src/tcw_back.sv
// Back end: cursor, screen store, scroll and clear passes, result register.
`timescale 1ns / 1ps
module tcw_back #(
    parameter int MAX_CELLS = 2048,
    parameter int TAB_WIDTH = 4,
    parameter int CELL_W    = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::geo_t       geo,
    input  logic [CELL_W-1:0]   cells,
    input  logic                q_valid,
    input  tcw_pkg::item_t      q_item,
    output logic                pop,
    output tcw_pkg::back_stat_t stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);
    localparam int AW    = $clog2(MAX_CELLS);
    localparam int CUR_W = $clog2(MAX_CELLS + 144);
    localparam int IW    = (AW > 11) ? AW + 1 : 12;
    // cursor / TAB_WIDTH by reciprocal multiply, exact over the cursor range
    localparam int     TAB_SH = CUR_W + $clog2(TAB_WIDTH);
    localparam longint TAB_M  = ((longint'(1) << TAB_SH) + longint'(TAB_WIDTH) - 1)
                                / longint'(TAB_WIDTH);
    localparam int     PW     = 2 * CUR_W + 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_PDIV, S_FF, S_SCHK,
        S_COPY, S_BLANK, S_ODIV, S_OWAIT, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CUR_W-1:0]  cursor_reg;
    logic [CELL_W-1:0] cnt_reg;
    tcw_pkg::op_t      op_reg;
    logic              in_rng_reg;
    logic [15:0]       entry_reg;
    logic [6:0]        col_reg;
    logic [5:0]        row_reg;
    logic              m_valid_reg;
    logic [15:0]       m_entry_reg;
    logic [6:0]        m_col_reg;
    logic [5:0]        m_row_reg;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [15:0]       wdata;
    logic [AW-1:0]     raddr;
    logic [15:0]       rdata;
    logic              div_start;
    logic [CUR_W-1:0]  div_a;
    logic [7:0]        div_b;
    logic              div_busy;
    logic              div_done;
    logic [CUR_W-1:0]  div_q;
    logic [7:0]        div_r;
    logic [CELL_W-1:0] last;
    logic [CELL_W-1:0] src;
    logic [IW-1:0]     idx_w;
    logic [15:0]       blank;
    logic [CUR_W-1:0]  cells_c;
    logic [CUR_W-1:0]  cols_c;
    logic              load;
    logic [PW-1:0]     tab_prod;
    logic [CUR_W-1:0]  tab_q;
    logic [CUR_W-1:0]  tab_rem;

    assign blank    = {geo.attr, 8'h00};
    assign cells_c  = CUR_W'(cells);
    assign cols_c   = CUR_W'(geo.ecols);
    assign last     = cells - CELL_W'(geo.ecols);
    assign src      = cnt_reg + CELL_W'(geo.ecols);
    assign idx_w    = IW'(q_item.idx);
    assign load     = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
    assign tab_prod = PW'(cursor_reg) * PW'(TAB_M);
    assign tab_q    = CUR_W'(tab_prod >> TAB_SH);
    assign tab_rem  = cursor_reg - tab_q * CUR_W'(TAB_WIDTH);

    tcw_ram #(.WIDTH(16), .DEPTH(MAX_CELLS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    tcw_div #(.AW(CUR_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        we        = 1'b0;
        waddr     = cnt_reg[AW-1:0];
        wdata     = blank;
        raddr     = src[AW-1:0];
        pop       = 1'b0;
        div_start = 1'b0;
        div_a     = cursor_reg;
        div_b     = geo.ecols;
        case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                wdata = 16'h0000;
            end
            S_IDLE:
            begin
                raddr = idx_w[AW-1:0];
                if (!geo.fix && q_valid)
                begin
                    pop = 1'b1;
                    if (q_item.op == tcw_pkg::OP_PRINT)
                    begin
                        we    = 1'b1;
                        waddr = cursor_reg[AW-1:0];
                        wdata = {geo.attr, q_item.ch};
                    end
                    if (q_item.op == tcw_pkg::OP_NL || q_item.op == tcw_pkg::OP_CR)
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_FF:    we = 1'b1;
            S_COPY:
            begin
                // read runs one cell ahead of the write
                we    = cnt_reg != '0;
                waddr = AW'(cnt_reg - 1'b1);
                wdata = rdata;
            end
            S_BLANK: we = 1'b1;
            S_ODIV:  div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            entry_reg <= in_rng_reg ? rdata : 16'h0000;
        end
        else if (state_reg == S_IDLE && pop)
        begin
            entry_reg <= 16'h0000;
        end
        if (state_reg == S_OWAIT && div_done)
        begin
            col_reg <= div_r[6:0];
            row_reg <= div_q[5:0];
        end
        if (load)
        begin
            m_entry_reg <= entry_reg;
            m_col_reg   <= col_reg;
            m_row_reg   <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            cursor_reg  <= '0;
            cnt_reg     <= '0;
            op_reg      <= tcw_pkg::OP_NOP;
            in_rng_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CELL_W'(MAX_CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (geo.fix)
                    begin
                        if (cursor_reg >= cells_c)
                        begin
                            cursor_reg <= cells_c - 1'b1;
                        end
                    end
                    else if (q_valid)
                    begin
                        op_reg     <= q_item.op;
                        in_rng_reg <= (IW + 1)'(idx_w) < (IW + 1)'(MAX_CELLS);
                        cnt_reg    <= '0;
                        case (q_item.op)
                            tcw_pkg::OP_READ:  state_reg <= S_RD;
                            tcw_pkg::OP_PRINT:
                            begin
                                cursor_reg <= cursor_reg + 1'b1;
                                state_reg  <= S_SCHK;
                            end
                            tcw_pkg::OP_BS:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_reg <= cursor_reg - 1'b1;
                                end
                                state_reg <= S_SCHK;
                            end
                            tcw_pkg::OP_VT:
                            begin
                                cursor_reg <= cursor_reg + cols_c;
                                state_reg  <= S_SCHK;
                            end
                            tcw_pkg::OP_TAB:
                            begin
                                cursor_reg <= cursor_reg + CUR_W'(TAB_WIDTH) - tab_rem;
                                state_reg  <= S_SCHK;
                            end
                            tcw_pkg::OP_NL,
                            tcw_pkg::OP_CR:    state_reg <= S_PDIV;
                            tcw_pkg::OP_FF:    state_reg <= S_FF;
                            default:           state_reg <= S_ODIV;
                        endcase
                    end
                end
                S_RD:    state_reg <= S_ODIV;
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        case (op_reg)
                            tcw_pkg::OP_NL:
                                cursor_reg <= CUR_W'((div_q + 1'b1) * geo.ecols);
                            default:
                                cursor_reg <= CUR_W'(div_q * geo.ecols);
                        endcase
                        state_reg <= S_SCHK;
                    end
                end
                S_FF:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == cells - 1'b1)
                    begin
                        cursor_reg <= '0;
                        state_reg  <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    cnt_reg <= '0;
                    state_reg <= (cursor_reg >= cells_c) ? S_COPY : S_ODIV;
                end
                S_COPY:
                begin
                    if (cnt_reg == last)
                    begin
                        state_reg <= S_BLANK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_BLANK:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == cells - 1'b1)
                    begin
                        cursor_reg <= cursor_reg - cols_c;
                        state_reg  <= S_SCHK;
                    end
                end
                S_ODIV:  state_reg <= S_OWAIT;
                S_OWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign stat.clearing = state_reg == S_CLR;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = {3'd0, m_row_reg, m_col_reg, m_entry_reg};

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !pop)
        else $error("queue popped during clearing pass");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!m_valid_reg || m_tready))
        else $error("result overwrote a pending beat");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_valid_reg)
        else $error("loaded result not presented");
endmodule

>>> verif/testbench.sv
// Self-checking testbench for the text console writer unit.
`timescale 1ns / 1ps
module testbench;

    localparam int CELLS_MAX = 2048;
    localparam int TABW      = 4;
    localparam int DRAIN_CYC = 12000;   // worst single item: scroll/clear plus divider passes

    typedef struct {
        logic        cmd;
        logic [7:0]  ch;
        logic [10:0] idx;
    } beat_in_t;

    typedef struct {
        logic [15:0] entry;
        logic [6:0]  col;
        logic [5:0]  row;
    } beat_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    text_console_writer_unit dut (.*);

    // Shadow copy of the console
    logic [15:0] shadow_cells [CELLS_MAX];
    int unsigned shadow_cursor;
    logic        sh_enable;
    logic [7:0]  sh_columns;
    logic [6:0]  sh_rows;
    logic [3:0]  sh_fore;
    logic [3:0]  sh_back;

    beat_in_t  pending_beats [$];
    beat_out_t expected_cells [$];
    int        error_count;
    bit        hold_sink;       // forced long stall on the result side
    int        sink_hold_cyc;
    int        sink_gap;

    initial begin
        clk = 1'b0;
    end
    always #5 clk = ~clk;

    // Effective geometry
    function automatic int unsigned geo_cols();
        int unsigned c;
        c = sh_columns;
        if (c < 1) c = 1;
        if (c > 128) c = 128;
        return c;
    endfunction

    function automatic int unsigned geo_rows();
        int unsigned r;
        r = sh_rows;
        if (r < 1) r = 1;
        if (r > 64) r = 64;
        if (r > CELLS_MAX / geo_cols()) r = CELLS_MAX / geo_cols();
        return r;
    endfunction

    function automatic logic [15:0] blank_cell();
        return {sh_back, sh_fore, 8'h00};
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        int unsigned n;
        case (idx)
            tcw_pkg::REG_ENABLE:  sh_enable = val[0];
            tcw_pkg::REG_COLUMNS: sh_columns = val[7:0];
            tcw_pkg::REG_ROWS:    sh_rows = val[6:0];
            tcw_pkg::REG_FORE:    sh_fore = val[3:0];
            tcw_pkg::REG_BACK:    sh_back = val[3:0];
            default: ;
        endcase
        if (idx == tcw_pkg::REG_COLUMNS || idx == tcw_pkg::REG_ROWS) begin
            n = geo_cols() * geo_rows();
            if (shadow_cursor >= n) shadow_cursor = n - 1;
        end
    endfunction

    // Advance the shadow console by one input beat and return its result
    function automatic beat_out_t console_step(beat_in_t b);
        beat_out_t   r;
        int unsigned cols, rws, n, last;
        cols = geo_cols();
        rws  = geo_rows();
        n    = cols * rws;
        r.entry = '0;
        if (b.cmd == tcw_pkg::CMD_PUT) begin
            if (sh_enable) begin
                if (b.ch >= tcw_pkg::CH_SPACE && b.ch <= tcw_pkg::CH_TILDE) begin
                    if (shadow_cursor < CELLS_MAX)
                        shadow_cells[shadow_cursor] = {sh_back, sh_fore, b.ch};
                    shadow_cursor++;
                end else if (b.ch == tcw_pkg::CH_BS) begin
                    if (shadow_cursor > 0) shadow_cursor--;
                end else if (b.ch == tcw_pkg::CH_TAB) begin
                    shadow_cursor += TABW - shadow_cursor % TABW;
                end else if (b.ch == tcw_pkg::CH_NL) begin
                    shadow_cursor = (shadow_cursor / cols + 1) * cols;
                end else if (b.ch == tcw_pkg::CH_VT) begin
                    shadow_cursor += cols;
                end else if (b.ch == tcw_pkg::CH_FF) begin
                    for (int i = 0; i < n; i++) shadow_cells[i] = blank_cell();
                    shadow_cursor = 0;
                end else if (b.ch == tcw_pkg::CH_CR) begin
                    shadow_cursor = (shadow_cursor / cols) * cols;
                end
                // scroll until the cursor is back on screen
                while (shadow_cursor >= n) begin
                    last = (rws - 1) * cols;
                    for (int i = 0; i < last; i++) shadow_cells[i] = shadow_cells[i + cols];
                    for (int i = 0; i < cols; i++) shadow_cells[last + i] = blank_cell();
                    shadow_cursor -= cols;
                end
            end
        end else if (b.idx < CELLS_MAX) begin
            r.entry = shadow_cells[b.idx];
        end
        r.col = 7'(shadow_cursor % cols);
        r.row = 6'(shadow_cursor / cols);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Driver: pops pending beats, random gaps, one NBA per signal per edge
    int drv_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            drv_gap  <= 0;
        end else begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) expected_cells.push_back(console_step(pending_beats.pop_front()));
                if (drv_gap > 0 || pending_beats.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (drv_gap > 0) drv_gap <= drv_gap - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, pending_beats[0].idx, pending_beats[0].ch};
                    s_tuser  <= pending_beats[0].cmd;
                    drv_gap  <= pick_gap();
                end
            end
        end
    end

    // Monitor: compares each result beat with the oldest expectation
    beat_out_t want;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            sink_hold_cyc <= 0;
            sink_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch("unexpected beat", int'(m_tdata), 0);
                end else begin
                    want = expected_cells.pop_front();
                    if (m_tdata[15:0] != want.entry)
                        report_mismatch("cell_entry", int'(m_tdata[15:0]), int'(want.entry));
                    if (m_tdata[22:16] != want.col)
                        report_mismatch("cursor_col", int'(m_tdata[22:16]), int'(want.col));
                    if (m_tdata[28:23] != want.row)
                        report_mismatch("cursor_row", int'(m_tdata[28:23]), int'(want.row));
                    if (m_tdata[31:29] != 3'b0)
                        report_mismatch("pad bits", int'(m_tdata[31:29]), 0);
                end
            end
            if (hold_sink && sink_hold_cyc < 400) begin
                // long hold-off so the input queue fills and stalls
                m_tready <= 1'b0;
                sink_hold_cyc <= sink_hold_cyc + 1;
            end else if (sink_gap > 0) begin
                m_tready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                m_tready <= 1'b1;
                sink_gap <= ($urandom_range(0, 99) < 40) ? pick_gap() : 0;
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic queue_beat(logic cmd, logic [7:0] ch, logic [10:0] idx);
        beat_in_t b;
        b.cmd = cmd; b.ch = ch; b.idx = idx;
        pending_beats.push_back(b);
    endtask

    // Wait until every beat is sent and every result is out, then let the unit settle
    task automatic drain_all();
        wait (pending_beats.size() == 0 && !s_tvalid);
        wait (expected_cells.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Mostly printable text, a share of control bytes and noise
    function automatic logic [7:0] pick_char();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 8'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_TILDE));
        if (k < 66) return tcw_pkg::CH_BS;
        if (k < 71) return tcw_pkg::CH_TAB;
        if (k < 76) return tcw_pkg::CH_NL;
        if (k < 79) return tcw_pkg::CH_VT;
        if (k < 80) return tcw_pkg::CH_FF;
        if (k < 85) return tcw_pkg::CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(int count, int idx_span);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 25)
                queue_beat(tcw_pkg::CMD_READ, 8'($urandom), ($urandom_range(0, 9) == 0) ?
                           11'($urandom) : 11'($urandom_range(0, idx_span - 1)));
            else
                queue_beat(tcw_pkg::CMD_PUT, pick_char(), 11'($urandom));
        end
    endtask

    initial begin
        error_count = 0;
        hold_sink = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < CELLS_MAX; i++) shadow_cells[i] = '0;
        shadow_cursor = 0;
        sh_enable = 1'b0; sh_columns = 8'd80; sh_rows = 7'd25; sh_fore = 4'd15; sh_back = 4'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // disabled puts change nothing
        queue_beat(tcw_pkg::CMD_PUT, 8'h41, 11'd0);
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd0);
        drain_all();

        // tiny screen so scroll is quick to hit
        apb_write(tcw_pkg::REG_ENABLE, 32'd1);
        apb_write(tcw_pkg::REG_COLUMNS, 32'd5);
        apb_write(tcw_pkg::REG_ROWS, 32'd3);
        apb_write(tcw_pkg::REG_FORE, 32'd10);
        apb_write(tcw_pkg::REG_BACK, 32'd5);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_SPACE, 11'h7FF);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_TILDE, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, 8'h1F, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, 8'h7F, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, 8'hFF, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, 8'h00, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_NL, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_VT, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_VT, 11'd0);   // off the bottom: scroll
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd1);
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd10);
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd2047);
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd20); // outside screen, inside store
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_FF, 11'd0);
        queue_beat(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 11'd0);   // backspace at home
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd0);
        drain_all();

        // geometry shrink to a one-cell screen
        apb_write(tcw_pkg::REG_ROWS, 32'd1);
        apb_write(tcw_pkg::REG_COLUMNS, 32'd0);       // clamped to one column
        queue_beat(tcw_pkg::CMD_PUT, 8'h5A, 11'd0);
        queue_beat(tcw_pkg::CMD_READ, 8'h00, 11'd0);
        drain_all();

        // random phases over several settings, extremes included
        apb_write(tcw_pkg::REG_COLUMNS, 32'd7);
        apb_write(tcw_pkg::REG_ROWS, 32'd4);
        // long sink stall while the source keeps offering
        hold_sink = 1'b1;
        random_phase(150, 64);
        drain_all();
        hold_sink = 1'b0;

        apb_write(tcw_pkg::REG_COLUMNS, 32'd255);     // clamps to 128 columns
        apb_write(tcw_pkg::REG_ROWS, 32'd127);        // clamps to 16 rows
        apb_write(tcw_pkg::REG_FORE, 32'd0);
        apb_write(tcw_pkg::REG_BACK, 32'd15);
        random_phase(120, 2048);
        drain_all();

        apb_write(tcw_pkg::REG_COLUMNS, 32'd1);
        apb_write(tcw_pkg::REG_ROWS, 32'd64);
        random_phase(150, 80);
        drain_all();

        apb_write(tcw_pkg::REG_ENABLE, 32'd0);
        random_phase(40, 2048);
        drain_all();

        apb_write(tcw_pkg::REG_ENABLE, 32'd1);
        apb_write(tcw_pkg::REG_COLUMNS, 32'd16);
        apb_write(tcw_pkg::REG_ROWS, 32'd8);
        apb_write(tcw_pkg::REG_FORE, 32'd7);
        apb_write(tcw_pkg::REG_BACK, 32'd2);
        random_phase(340, 160);
        drain_all();

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #200ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> text_console_writer_unit.f
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_div.sv
src/tcw_cfg.sv
src/tcw_front.sv
src/tcw_back.sv
src/text_console_writer_unit.sv
verif/testbench.sv
